>>> sv/tlru_pkg.sv
// Shared types, constants and helpers for the two-way LRU tag lookup.
// No dependencies; compiled first.
package tlru_pkg;

    localparam int NUM_SETS_DEF   = 64;
    localparam int LINE_BYTES_DEF = 32;

    localparam int ADDR_W   = 32;
    localparam int OFFSET_W = 5;
    localparam int BLOCK_W  = 27;
    localparam int SETIDX_W = 6;
    localparam int TAG_W    = 21;
    localparam int CNT_W    = 32;
    localparam int FILL_W   = 2;
    localparam int META_W   = FILL_W + 1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Per-set fill level codes
    localparam logic [FILL_W-1:0] FILL_NONE = 2'd0;
    localparam logic [FILL_W-1:0] FILL_ONE  = 2'd1;
    localparam logic [FILL_W-1:0] FILL_BOTH = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_sts;

    function automatic int floor_log2(input int v);
        int n;
        int x;
        n = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            n++;
        end
        return n;
    endfunction

endpackage

>>> sv/tlru_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/tlru_ctrl.sv
// Controller: clearing pass, request acceptance and result handover.
// Depends on tlru_pkg.
module tlru_ctrl import tlru_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_in_ready       = 1'b0;
        n_out_valid      = r_out_valid && !i_out_ready;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // commit only once the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> sv/tlru_dpath.sv
// Datapath: address split, tag and LRU stores, compare, counters, result regs.
// Depends on tlru_pkg and tlru_ram.
module tlru_dpath import tlru_pkg::*; #(
    parameter int NUM_SETS   = NUM_SETS_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [ADDR_W-1:0]   i_addr,
    output logic [OFFSET_W-1:0] o_byte_offset,
    output logic [BLOCK_W-1:0]  o_block_number,
    output logic [SETIDX_W-1:0] o_set_index,
    output logic                o_way_used,
    output logic [TAG_W-1:0]    o_line_tag,
    output logic                o_is_miss,
    output logic                o_did_replace,
    output logic [TAG_W-1:0]    o_evicted_tag,
    output logic [CNT_W-1:0]    o_hits_so_far,
    output logic [CNT_W-1:0]    o_misses_so_far
);

    localparam int OFF_W  = floor_log2(LINE_BYTES);
    localparam int SET_W  = floor_log2(NUM_SETS);
    localparam int SETS   = 1 << SET_W;
    localparam int TAG_SH = OFF_W + SET_W;

    localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((1 << OFF_W) - 1);
    localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'((1 << SET_W) - 1);
    localparam logic [SET_W-1:0]  CLR_LAST = SET_W'(SETS - 1);

    logic [SET_W-1:0]  r_clr_idx;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_hit_total;
    logic [CNT_W-1:0]  r_miss_total;
    logic [CNT_W-1:0]  n_hit_total;
    logic [CNT_W-1:0]  n_miss_total;

    logic [OFFSET_W-1:0] r_byte_offset;
    logic [BLOCK_W-1:0]  r_block_number;
    logic [SETIDX_W-1:0] r_set_index;
    logic                r_way_used;
    logic [TAG_W-1:0]    r_line_tag;
    logic                r_is_miss;
    logic                r_did_replace;
    logic [TAG_W-1:0]    r_evicted_tag;

    logic [ADDR_W-1:0] in_block;
    logic [ADDR_W-1:0] cur_block;
    logic [ADDR_W-1:0] cur_set_full;
    logic [ADDR_W-1:0] cur_off_full;
    logic [ADDR_W-1:0] cur_tag_full;
    logic [SET_W-1:0]  cur_set;
    logic [TAG_W-1:0]  cur_tag;

    logic [META_W-1:0] meta_rdata;
    logic [TAG_W-1:0]  t0_rdata;
    logic [TAG_W-1:0]  t1_rdata;
    logic [FILL_W-1:0] fill;
    logic              lru;

    logic              way;
    logic              miss;
    logic              repl;
    logic [TAG_W-1:0]  evicted;
    logic              w0_we;
    logic              w1_we;
    logic [FILL_W-1:0] new_fill;
    logic              new_lru;

    logic              meta_we;
    logic [SET_W-1:0]  meta_waddr;
    logic [META_W-1:0] meta_wdata;

    // address split
    assign in_block     = i_addr >> OFF_W;
    assign cur_block    = r_addr >> OFF_W;
    assign cur_off_full = r_addr & OFF_MASK;
    assign cur_set_full = cur_block & SET_MASK;
    assign cur_tag_full = r_addr >> TAG_SH;
    assign cur_set      = cur_block[SET_W-1:0];
    assign cur_tag      = cur_tag_full[TAG_W-1:0];

    assign fill = meta_rdata[FILL_W-1:0];
    assign lru  = meta_rdata[META_W-1];

    always_comb begin
        way      = 1'b0;
        miss     = 1'b0;
        repl     = 1'b0;
        evicted  = '0;
        w0_we    = 1'b0;
        w1_we    = 1'b0;
        new_fill = fill;
        new_lru  = lru;
        case (fill)
            FILL_NONE: begin
                miss     = 1'b1;
                w0_we    = 1'b1;
                new_fill = FILL_ONE;
                new_lru  = 1'b0;
            end
            FILL_ONE: begin
                if (t0_rdata == cur_tag) begin
                    new_lru = 1'b0;
                end else begin
                    way      = 1'b1;
                    miss     = 1'b1;
                    w1_we    = 1'b1;
                    new_fill = FILL_BOTH;
                    new_lru  = 1'b1;
                end
            end
            default: begin
                // both ways valid
                if (t0_rdata == cur_tag) begin
                    new_lru = 1'b0;
                end else if (t1_rdata == cur_tag) begin
                    way     = 1'b1;
                    new_lru = 1'b1;
                end else begin
                    miss    = 1'b1;
                    repl    = 1'b1;
                    way     = ~lru;
                    evicted = lru ? t0_rdata : t1_rdata;
                    w0_we   = lru;
                    w1_we   = ~lru;
                    new_lru = ~lru;
                end
            end
        endcase
    end

    assign meta_we    = i_cmd.clear_step || i_cmd.commit;
    assign meta_waddr = i_cmd.clear_step ? r_clr_idx : cur_set;
    assign meta_wdata = i_cmd.clear_step ? '0 : {new_lru, new_fill};

    tlru_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (in_block[SET_W-1:0]),
        .o_rdata (meta_rdata)
    );

    tlru_ram #(.WIDTH(TAG_W), .DEPTH(SETS)) u_way0_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && w0_we),
        .i_waddr (cur_set),
        .i_wdata (cur_tag),
        .i_re    (i_cmd.accept),
        .i_raddr (in_block[SET_W-1:0]),
        .o_rdata (t0_rdata)
    );

    tlru_ram #(.WIDTH(TAG_W), .DEPTH(SETS)) u_way1_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && w1_we),
        .i_waddr (cur_set),
        .i_wdata (cur_tag),
        .i_re    (i_cmd.accept),
        .i_raddr (in_block[SET_W-1:0]),
        .o_rdata (t1_rdata)
    );

    // saturating totals
    always_comb begin
        n_hit_total  = r_hit_total;
        n_miss_total = r_miss_total;
        if (miss) begin
            if (r_miss_total != CNT_MAX) begin
                n_miss_total = r_miss_total + CNT_W'(1);
            end
        end else begin
            if (r_hit_total != CNT_MAX) begin
                n_hit_total = r_hit_total + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx    <= '0;
            r_hit_total  <= '0;
            r_miss_total <= '0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
            end
            if (i_cmd.commit) begin
                r_hit_total  <= n_hit_total;
                r_miss_total <= n_miss_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr <= i_addr;
        end
        if (i_cmd.commit) begin
            r_byte_offset  <= cur_off_full[OFFSET_W-1:0];
            r_block_number <= cur_block[BLOCK_W-1:0];
            r_set_index    <= cur_set_full[SETIDX_W-1:0];
            r_way_used     <= way;
            r_line_tag     <= cur_tag;
            r_is_miss      <= miss;
            r_did_replace  <= repl;
            r_evicted_tag  <= evicted;
        end
    end

    assign o_sts.clear_last = (r_clr_idx == CLR_LAST);

    assign o_byte_offset   = r_byte_offset;
    assign o_block_number  = r_block_number;
    assign o_set_index     = r_set_index;
    assign o_way_used      = r_way_used;
    assign o_line_tag      = r_line_tag;
    assign o_is_miss       = r_is_miss;
    assign o_did_replace   = r_did_replace;
    assign o_evicted_tag   = r_evicted_tag;
    assign o_hits_so_far   = r_hit_total;
    assign o_misses_so_far = r_miss_total;

endmodule

>>> sv/two_way_lru_cache_tag_lookup.sv
// Top level of the two-way set-associative LRU tag lookup.
// Depends on tlru_pkg, tlru_ctrl, tlru_dpath (and tlru_ram below it).
//
// Usage:
//  - Request channel: i_in_valid / o_in_ready with i_addr, one byte address
//    per request. Result channel: o_out_valid / i_out_ready with the split
//    address fields, hit/miss, way, eviction info and running totals.
//  - Lookup: a request accepted in ST_IDLE reads its set from the stores,
//    then ST_LOOKUP commits its result once the result register is free.
//  - Request flow: no new request is taken before the previous one has
//    committed. The tag and LRU stores are RAMs with a registered read:
//    the set is read in ST_IDLE, compared and written in ST_LOOKUP.
//  - A new request is taken while the previous result still waits; that
//    request then holds in the lookup cycle (no RAM write) until the
//    result register is emptied.
//  - Reset (i_rst_n low, synchronous) clears the controller and totals,
//    then a clearing pass zeroes the per-set fill/LRU store, one set per
//    cycle, all 2**floor(log2(NUM_SETS)) sets (64 by default). o_in_ready
//    stays low for that pass. Tag stores are never cleared; a way's tag
//    is only read once its fill level marks it valid.
//  - Hit and miss totals saturate at all ones.
module two_way_lru_cache_tag_lookup import tlru_pkg::*; #(
    parameter int NUM_SETS   = NUM_SETS_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ADDR_W-1:0]   i_addr,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OFFSET_W-1:0] o_byte_offset,
    output logic [BLOCK_W-1:0]  o_block_number,
    output logic [SETIDX_W-1:0] o_set_index,
    output logic                o_way_used,
    output logic [TAG_W-1:0]    o_line_tag,
    output logic                o_is_miss,
    output logic                o_did_replace,
    output logic [TAG_W-1:0]    o_evicted_tag,
    output logic [CNT_W-1:0]    o_hits_so_far,
    output logic [CNT_W-1:0]    o_misses_so_far
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing: clear pass, accept, lookup/commit
    tlru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // stores, compare, LRU update and result registers
    tlru_dpath #(
        .NUM_SETS   (NUM_SETS),
        .LINE_BYTES (LINE_BYTES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_addr          (i_addr),
        .o_byte_offset   (o_byte_offset),
        .o_block_number  (o_block_number),
        .o_set_index     (o_set_index),
        .o_way_used      (o_way_used),
        .o_line_tag      (o_line_tag),
        .o_is_miss       (o_is_miss),
        .o_did_replace   (o_did_replace),
        .o_evicted_tag   (o_evicted_tag),
        .o_hits_so_far   (o_hits_so_far),
        .o_misses_so_far (o_misses_so_far)
    );

endmodule
